// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge of clk outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Check that cond never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

// ----- hdl/pit2_pkg.sv -----
package pit2_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 32;

    // Dividend width of the 2443632 / latch division.
    localparam int SPK_NUM_WIDTH = 22;

    localparam logic [SPK_NUM_WIDTH-1:0] SPEAKER_NUM = 22'd2443632;
    localparam logic [15:0] SPEAKER_MIN_LATCH = 16'd36;
    localparam logic [16:0] FULL_COUNT = 17'h10000;

    localparam logic [7:0] MODE_RW_SET = 8'h30;
    localparam logic [7:0] MODE_RW_CLEAR = 8'hCF;

    // Counting modes that always run over the full 16-bit range.
    localparam logic [2:0] OP_MODE_0 = 3'd0;
    localparam logic [2:0] OP_MODE_4 = 3'd4;

    // Control byte bits 7:6: counter 2 select (3 is read-back, ignored).
    localparam logic [1:0] CTL_SEL_CNT2 = 2'b10;

    typedef enum logic [1:0] {
        FUNC_READ    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_CONTROL = 2'd2,
        FUNC_TICK    = 2'd3
    } func_t;

    // Read/write toggle in mode word bits 5:4.
    typedef enum logic [1:0] {
        RW_NONE = 2'd0,
        RW_LSB  = 2'd1,
        RW_MSB  = 2'd2,
        RW_WORD = 2'd3
    } rw_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [16:0] speaker_increment;
    } rsp_t;

endpackage

// ----- hdl/pit_channel2_speaker_counter.sv -----
// Channel | Direction | Handshake          | Word
// cmd     | in        | cmd_valid/cmd_stall | cmd_t: func, data_byte
// rsp     | out       | rsp_valid/rsp_stall | rsp_t: read_data, speaker_increment
//
// Each command word gives exactly one response word.
// Sequence per word: accept, execute, finish; a count capture in modes other
// than 0/4 or a restart with latch > 36 adds the divide and commit states of
// the bit-serial restoring divider (DIV_WIDTH = max(TICK_COUNT_WIDTH, 22)).
// Reset: rst_n clears all control state and the counter registers at once.
// Stalls: cmd_stall is high from acceptance until the response is loaded
// into the output register; a held response does not block the next command
// until that command's own response is ready.
module pit_channel2_speaker_counter
    import pit2_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // The divider serves both the count capture (ticks mod reload) and the
    // speaker step (2443632 / latch); it must hold the wider dividend.
    localparam int DIV_WIDTH = (TICK_COUNT_WIDTH > SPK_NUM_WIDTH) ?
                               TICK_COUNT_WIDTH : SPK_NUM_WIDTH;
    localparam int CNT_WIDTH = $clog2(DIV_WIDTH + 1);

    state_t state_reg, state_next;

    cmd_t cmd_item_reg, cmd_item_next;

    logic [7:0]  mode_word_reg, mode_word_next;
    logic [15:0] write_latch_reg, write_latch_next;
    logic [15:0] read_latch_reg, read_latch_next;
    logic [16:0] reload_count_reg, reload_count_next;
    logic        relatch_pending_reg, relatch_pending_next;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic [16:0] speaker_step_reg, speaker_step_next;

    // Shared divider: quotient register also shifts the dividend out.
    logic [DIV_WIDTH-1:0] div_quo_reg, div_quo_next;
    logic [15:0]          div_rem_reg, div_rem_next;
    logic [16:0]          div_den_reg, div_den_next;
    logic [CNT_WIDTH-1:0] div_cnt_reg, div_cnt_next;
    logic                 div_is_mod_reg, div_is_mod_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    // Decoded item and divider step.
    logic        cmd_accept;
    logic        mode_full;
    rw_t         rw_mode;
    logic [15:0] wr_latch;
    logic        wr_restart;
    logic [16:0] wr_reload;
    logic        ctl_capture;
    logic        ctl_mode;
    logic        need_mod;
    logic        need_div;
    logic        rsp_load;
    logic [16:0] div_trial;
    logic        div_ge;
    logic [15:0] div_rem_step;
    logic [16:0] mod_den;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Decode the held item against the current counter state.
    always_comb
    begin
        mode_full = (mode_word_reg[3:1] == OP_MODE_0) || (mode_word_reg[3:1] == OP_MODE_4);
        rw_mode   = rw_t'(mode_word_reg[5:4]);

        wr_restart = 1'b1;
        unique case (rw_mode)
            RW_NONE: wr_latch = {cmd_item_reg.data_byte, write_latch_reg[7:0]};
            RW_LSB:  wr_latch = {8'h00, cmd_item_reg.data_byte};
            RW_MSB:  wr_latch = {cmd_item_reg.data_byte, 8'h00};
            RW_WORD:
            begin
                wr_latch   = {write_latch_reg[15:8], cmd_item_reg.data_byte};
                wr_restart = 1'b0;
            end
            default: wr_latch = write_latch_reg;
        endcase

        if (mode_full || (wr_latch == 16'd0))
            wr_reload = FULL_COUNT;
        else
            wr_reload = {1'b0, wr_latch};

        ctl_capture = (cmd_item_reg.data_byte[7:6] == CTL_SEL_CNT2) &&
                      (cmd_item_reg.data_byte[5:4] == RW_NONE);
        ctl_mode    = (cmd_item_reg.data_byte[7:6] == CTL_SEL_CNT2) &&
                      (cmd_item_reg.data_byte[5:4] != RW_NONE);

        need_mod = !mode_full &&
                   (((cmd_item_reg.func == FUNC_READ) && relatch_pending_reg) ||
                    ((cmd_item_reg.func == FUNC_CONTROL) && ctl_capture));
        need_div = (cmd_item_reg.func == FUNC_WRITE) && wr_restart &&
                   (wr_latch > SPEAKER_MIN_LATCH);

        rsp_load = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);

        mod_den = (reload_count_reg == 17'd0) ? FULL_COUNT : reload_count_reg;

        // One restoring step: bring in the next dividend bit, try subtract.
        div_trial    = {div_rem_reg, div_quo_reg[DIV_WIDTH-1]};
        div_ge       = (div_trial >= div_den_reg);
        div_rem_step = div_ge ? 16'(div_trial - div_den_reg) : div_trial[15:0];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (need_mod || need_div)
                    state_next = ST_DIV;
                else
                    state_next = ST_FINISH;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == CNT_WIDTH'(1))
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (rsp_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and output word.
    always_comb
    begin
        cmd_item_next        = cmd_item_reg;
        mode_word_next       = mode_word_reg;
        write_latch_next     = write_latch_reg;
        read_latch_next      = read_latch_reg;
        reload_count_next    = reload_count_reg;
        relatch_pending_next = relatch_pending_reg;
        elapsed_ticks_next   = elapsed_ticks_reg;
        speaker_step_next    = speaker_step_reg;
        div_quo_next         = div_quo_reg;
        div_rem_next         = div_rem_reg;
        div_den_next         = div_den_reg;
        div_cnt_next         = div_cnt_reg;
        div_is_mod_next      = div_is_mod_reg;
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                    cmd_item_next = cmd;
            end
            ST_EXEC:
            begin
                // Start the divider for a capture outside modes 0/4.
                if (need_mod)
                begin
                    div_quo_next    = DIV_WIDTH'(elapsed_ticks_reg);
                    div_rem_next    = 16'd0;
                    div_den_next    = mod_den;
                    div_cnt_next    = CNT_WIDTH'(DIV_WIDTH);
                    div_is_mod_next = 1'b1;
                end
                unique case (cmd_item_reg.func)
                    FUNC_READ:
                    begin
                        if (relatch_pending_reg && mode_full)
                        begin
                            read_latch_next      = 16'd0 - elapsed_ticks_reg[15:0];
                            relatch_pending_next = 1'b0;
                        end
                    end
                    FUNC_WRITE:
                    begin
                        write_latch_next = wr_latch;
                        if (rw_mode == RW_NONE)
                            mode_word_next = mode_word_reg | MODE_RW_SET;
                        if (rw_mode == RW_WORD)
                            mode_word_next = mode_word_reg & MODE_RW_CLEAR;
                        if (wr_restart)
                        begin
                            reload_count_next  = wr_reload;
                            elapsed_ticks_next = '0;
                            if (need_div)
                            begin
                                div_quo_next    = DIV_WIDTH'(SPEAKER_NUM);
                                div_rem_next    = 16'd0;
                                div_den_next    = {1'b0, wr_latch};
                                div_cnt_next    = CNT_WIDTH'(DIV_WIDTH);
                                div_is_mod_next = 1'b0;
                            end
                            else
                                speaker_step_next = 17'd0;
                        end
                    end
                    FUNC_CONTROL:
                    begin
                        if (ctl_mode)
                            mode_word_next = cmd_item_reg.data_byte;
                        if (ctl_capture && mode_full)
                        begin
                            read_latch_next      = 16'd0 - elapsed_ticks_reg[15:0];
                            relatch_pending_next = 1'b0;
                        end
                    end
                    FUNC_TICK:
                    begin
                        // Saturate at all ones.
                        if (!(&elapsed_ticks_reg))
                            elapsed_ticks_next = elapsed_ticks_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV:
            begin
                div_rem_next = div_rem_step;
                div_quo_next = {div_quo_reg[DIV_WIDTH-2:0], div_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            ST_COMMIT:
            begin
                if (div_is_mod_reg)
                begin
                    read_latch_next      = 16'(div_den_reg - {1'b0, div_rem_reg});
                    relatch_pending_next = 1'b0;
                end
                else
                    speaker_step_next = div_quo_reg[16:0];
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_next.read_data          = 8'h00;
                    rsp_next.speaker_increment  = speaker_step_reg;
                    if (cmd_item_reg.func == FUNC_READ)
                    begin
                        unique case (rw_mode)
                            RW_NONE:
                            begin
                                relatch_pending_next = 1'b1;
                                mode_word_next       = mode_word_reg | MODE_RW_SET;
                                rsp_next.read_data   = read_latch_reg[15:8];
                            end
                            RW_LSB:
                            begin
                                relatch_pending_next = 1'b1;
                                rsp_next.read_data   = read_latch_reg[7:0];
                            end
                            RW_MSB:
                            begin
                                relatch_pending_next = 1'b1;
                                rsp_next.read_data   = read_latch_reg[15:8];
                            end
                            RW_WORD:
                            begin
                                mode_word_next     = mode_word_reg & MODE_RW_CLEAR;
                                rsp_next.read_data = read_latch_reg[7:0];
                            end
                            default:
                                rsp_next.read_data = 8'h00;
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            mode_word_reg       <= 8'h00;
            write_latch_reg     <= 16'd0;
            read_latch_reg      <= 16'd0;
            reload_count_reg    <= FULL_COUNT;
            relatch_pending_reg <= 1'b0;
            elapsed_ticks_reg   <= '0;
            speaker_step_reg    <= 17'd0;
            div_cnt_reg         <= '0;
            div_is_mod_reg      <= 1'b0;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            mode_word_reg       <= mode_word_next;
            write_latch_reg     <= write_latch_next;
            read_latch_reg      <= read_latch_next;
            reload_count_reg    <= reload_count_next;
            relatch_pending_reg <= relatch_pending_next;
            elapsed_ticks_reg   <= elapsed_ticks_next;
            speaker_step_reg    <= speaker_step_next;
            div_cnt_reg         <= div_cnt_next;
            div_is_mod_reg      <= div_is_mod_next;
            rsp_valid_reg       <= rsp_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        cmd_item_reg <= cmd_item_next;
        div_quo_reg  <= div_quo_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// ----- hdl/pit2_checker.sv -----
`include "assert_macros.svh"

module pit2_checker
    import pit2_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input cmd_t cmd,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // Hold off further commands once a word is taken.
    `ASSERT_PROP(a_stall_after_accept, clk, rst_n, cmd_valid && !cmd_stall |=> cmd_stall)

    // A response never appears in the cycle right after a command is taken.
    `ASSERT_PROP(a_no_early_rsp, clk, rst_n, cmd_valid && !cmd_stall |=> !$rose(rsp_valid))

    // Speaker step stays within 2443632 / 37.
    `ASSERT_NEVER(a_step_range, clk, rst_n, rsp_valid && (rsp.speaker_increment > 17'd66044))

    // A stalled response holds.
    `ASSERT_PROP(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

endmodule

bind pit_channel2_speaker_counter pit2_checker u_pit2_checker (.*);
